// ===== src/bmbx_pkg.sv =====
`default_nettype none

package bmbx_pkg;

	localparam int unsigned STATUS_W = 3;

	typedef enum logic [STATUS_W-1:0] {
		ST_QUEUED    = 3'd0,
		ST_HANDED    = 3'd1,
		ST_DELIVERED = 3'd2,
		ST_BLOCKED   = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic load;
	} ctl_cmd_t;

endpackage

`default_nettype wire

// ===== src/bmbx_if.sv =====
`default_nettype none

interface bmbx_req_if #(
	parameter int unsigned MSG_W = 32,
	parameter int unsigned TID_W = 8
);
	logic             valid;
	logic             ready;
	logic             operation;
	logic [MSG_W-1:0] message;
	logic [TID_W-1:0] thread_id;

	modport source (output valid, operation, message, thread_id, input ready);
	modport sink   (input valid, operation, message, thread_id, output ready);
endinterface

interface bmbx_rsp_if #(
	parameter int unsigned MSG_W = 32,
	parameter int unsigned TID_W = 8,
	parameter int unsigned CNT_W = 5
);
	logic             valid;
	logic             ready;
	logic [2:0]       status;
	logic [TID_W-1:0] out_thread;
	logic [MSG_W-1:0] out_message;
	logic [CNT_W-1:0] message_count;

	modport source (output valid, status, out_thread, out_message, message_count,
		input ready);
	modport sink   (input valid, status, out_thread, out_message, message_count,
		output ready);
endinterface

`default_nettype wire

// ===== src/bmbx_ctrl.sv =====
`default_nettype none

module bmbx_ctrl
	import bmbx_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_ready,
	output logic          rsp_valid,
	input  wire logic     rsp_ready,
	output ctl_cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	// A waiting result that is being taken frees the block for the next beat.
	assign req_ready  = (state_q == S_IDLE) || ((state_q == S_DONE) && rsp_ready);
	assign accept     = req_valid && req_ready;
	assign rsp_valid  = (state_q == S_DONE);
	assign cmd.accept = accept;
	assign cmd.load   = (state_q == S_EXEC);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (accept) state_d = S_EXEC;
				else if (rsp_ready) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_no_accept_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |-> !accept)
		else $error("beat accepted while an operation is in flight");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 rsp_valid)
		else $error("result not presented two cycles after acceptance");

endmodule

`default_nettype wire

// ===== src/bmbx_dp.sv =====
`default_nettype none

module bmbx_dp
	import bmbx_pkg::*;
#(
	parameter int unsigned MSG_DEPTH    = 16,
	parameter int unsigned WAITER_DEPTH = 16,
	parameter int unsigned MSG_W        = 32,
	parameter int unsigned TID_W        = 8,
	parameter int unsigned CNT_W        = 5
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ctl_cmd_t         cmd,
	input  wire logic             operation,
	input  wire logic [MSG_W-1:0] message,
	input  wire logic [TID_W-1:0] thread_id,
	output logic [STATUS_W-1:0]   status,
	output logic [TID_W-1:0]      out_thread,
	output logic [MSG_W-1:0]      out_message,
	output logic [CNT_W-1:0]      message_count
);

	localparam int unsigned MA_W   = $clog2(MSG_DEPTH);
	localparam int unsigned WA_W   = $clog2(WAITER_DEPTH);
	localparam int unsigned WCNT_W = $clog2(WAITER_DEPTH + 1);

	logic [MSG_W-1:0] msg_mem [MSG_DEPTH];
	logic [TID_W-1:0] wt_mem  [WAITER_DEPTH];

	logic [MA_W-1:0]   mhead_q, mtail_q;
	logic [CNT_W-1:0]  mfill_q, mfill_d;
	logic [WA_W-1:0]   whead_q, wtail_q;
	logic [WCNT_W-1:0] wfill_q, wfill_d;

	status_t          st_d, st_s1;
	logic             m_push, m_pop, w_push, w_pop;
	logic [MSG_W-1:0] msg_s1, mrd_s1;
	logic [TID_W-1:0] tid_s1, wrd_s1;
	logic [CNT_W-1:0] cnt_s1;

	status_t          status_q;
	logic [TID_W-1:0] thread_q;
	logic [MSG_W-1:0] message_q;
	logic [CNT_W-1:0] count_q;

	always_comb begin
		st_d   = ST_FULL;
		m_push = 1'b0;
		m_pop  = 1'b0;
		w_push = 1'b0;
		w_pop  = 1'b0;
		if (!operation) begin
			if (wfill_q != '0) begin
				st_d  = ST_HANDED;
				w_pop = 1'b1;
			end else if (mfill_q != CNT_W'(MSG_DEPTH)) begin
				st_d   = ST_QUEUED;
				m_push = 1'b1;
			end
		end else begin
			if (mfill_q != '0) begin
				st_d  = ST_DELIVERED;
				m_pop = 1'b1;
			end else if (wfill_q != WCNT_W'(WAITER_DEPTH)) begin
				st_d   = ST_BLOCKED;
				w_push = 1'b1;
			end
		end
	end

	assign mfill_d = mfill_q + CNT_W'(m_push) - CNT_W'(m_pop);
	assign wfill_d = wfill_q + WCNT_W'(w_push) - WCNT_W'(w_pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mhead_q <= '0;
			mtail_q <= '0;
			mfill_q <= '0;
			whead_q <= '0;
			wtail_q <= '0;
			wfill_q <= '0;
		end else if (cmd.accept) begin
			mfill_q <= mfill_d;
			wfill_q <= wfill_d;
			if (m_push) mtail_q <= (mtail_q == MA_W'(MSG_DEPTH - 1)) ? '0 : mtail_q + 1'b1;
			if (m_pop)  mhead_q <= (mhead_q == MA_W'(MSG_DEPTH - 1)) ? '0 : mhead_q + 1'b1;
			if (w_push) wtail_q <= (wtail_q == WA_W'(WAITER_DEPTH - 1)) ? '0 : wtail_q + 1'b1;
			if (w_pop)  whead_q <= (whead_q == WA_W'(WAITER_DEPTH - 1)) ? '0 : whead_q + 1'b1;
		end
	end

	// Both heads are read on every beat; only the branch taken uses the data.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			if (m_push) msg_mem[mtail_q] <= message;
			mrd_s1 <= msg_mem[mhead_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			if (w_push) wt_mem[wtail_q] <= thread_id;
			wrd_s1 <= wt_mem[whead_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			st_s1  <= st_d;
			msg_s1 <= message;
			tid_s1 <= thread_id;
			cnt_s1 <= mfill_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			status_q <= st_s1;
			count_q  <= cnt_s1;
			case (st_s1)
				ST_HANDED: begin
					thread_q  <= wrd_s1;
					message_q <= msg_s1;
				end
				ST_DELIVERED: begin
					thread_q  <= tid_s1;
					message_q <= mrd_s1;
				end
				default: begin
					thread_q  <= '0;
					message_q <= '0;
				end
			endcase
		end
	end

	assign status        = status_q;
	assign out_thread    = thread_q;
	assign out_message   = message_q;
	assign message_count = count_q;

	a_msg_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		mfill_q <= CNT_W'(MSG_DEPTH))
		else $error("message fill beyond depth");

	a_wt_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wfill_q <= WCNT_W'(WAITER_DEPTH))
		else $error("waiter fill beyond depth");

	a_one_side_only: assert property (@(posedge clk) disable iff (!arst_n)
		!((mfill_q != '0) && (wfill_q != '0)))
		else $error("messages and waiters queued at the same time");

	a_handed_no_queue: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && (st_d == ST_HANDED)) |=> (mfill_q == '0))
		else $error("hand-over left messages queued");

endmodule

`default_nettype wire

// ===== src/blocking_mailbox_top.sv =====
// Channel | Dir | Fields                                             | Handshake
// req     | in  | operation, message, thread_id                      | valid/ready
// rsp     | out | status, out_thread, out_message, message_count     | valid/ready
//
// One result beat for every request beat; an accepted beat passes through EXEC, then DONE.
// A new request is taken while idle or in the cycle its predecessor's result is
// taken, so the block never takes a new beat before the last one's result is gone;
// the registered read of the message and waiter memories is why EXEC comes first.
// Reset empties both queues at once; the memories need no clearing.
// A stalled result holds, and no request is taken until it is gone.
`default_nettype none

module blocking_mailbox_top
	import bmbx_pkg::*;
#(
	parameter int unsigned MSG_DEPTH       = 16,
	parameter int unsigned WAITER_DEPTH    = 16,
	parameter int unsigned MSG_WIDTH       = 32,
	parameter int unsigned THREAD_ID_WIDTH = 8
) (
	input wire logic  clk,
	input wire logic  arst_n,
	bmbx_req_if.sink  req,
	bmbx_rsp_if.source rsp
);

	localparam int unsigned CNT_W = $clog2(MSG_DEPTH + 1);

	ctl_cmd_t cmd;

	bmbx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	bmbx_dp #(
		.MSG_DEPTH    (MSG_DEPTH),
		.WAITER_DEPTH (WAITER_DEPTH),
		.MSG_W        (MSG_WIDTH),
		.TID_W        (THREAD_ID_WIDTH),
		.CNT_W        (CNT_W)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.operation     (req.operation),
		.message       (req.message),
		.thread_id     (req.thread_id),
		.status        (rsp.status),
		.out_thread    (rsp.out_thread),
		.out_message   (rsp.out_message),
		.message_count (rsp.message_count)
	);

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import bmbx_pkg::*;

	localparam int unsigned MSG_DEPTH    = 16;
	localparam int unsigned WAITER_DEPTH = 16;
	localparam int unsigned MSG_W        = 32;
	localparam int unsigned TID_W        = 8;
	localparam int unsigned CNT_W        = 5;

	localparam logic OP_SEND    = 1'b0;
	localparam logic OP_RECEIVE = 1'b1;

	typedef struct {
		status_t          status;
		logic [TID_W-1:0] thread;
		logic [MSG_W-1:0] message;
		logic [CNT_W-1:0] count;
	} mbx_reply_t;

	logic clk;
	logic arst_n;

	bmbx_req_if #(.MSG_W(MSG_W), .TID_W(TID_W)) req_ch ();
	bmbx_rsp_if #(.MSG_W(MSG_W), .TID_W(TID_W), .CNT_W(CNT_W)) rsp_ch ();

	blocking_mailbox_top #(
		.MSG_DEPTH(MSG_DEPTH),
		.WAITER_DEPTH(WAITER_DEPTH),
		.MSG_WIDTH(MSG_W),
		.THREAD_ID_WIDTH(TID_W)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// Shadow copy of the two queues held by the block.
	logic [MSG_W-1:0] queued_msgs[$];
	logic [TID_W-1:0] waiting_threads[$];
	mbx_reply_t       expected_replies[$];
	mbx_reply_t       oldest_reply;

	int unsigned errors = 0;
	bit          req_idle = 1'b0;
	bit          rsp_idle = 1'b0;
	int unsigned rsp_hold_cycles = 0;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	initial begin
		#1_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic mbx_reply_t predict_mailbox(input logic op, input logic [MSG_W-1:0] msg,
			input logic [TID_W-1:0] tid);
		mbx_reply_t r;
		r.thread = '0;
		r.message = '0;
		if (op == OP_SEND) begin
			if (waiting_threads.size() > 0) begin
				r.thread = waiting_threads.pop_front();
				r.message = msg;
				r.status = ST_HANDED;
			end else if (queued_msgs.size() >= MSG_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				queued_msgs.push_back(msg);
				r.status = ST_QUEUED;
			end
		end else begin
			if (queued_msgs.size() > 0) begin
				r.message = queued_msgs.pop_front();
				r.thread = tid;
				r.status = ST_DELIVERED;
			end else if (waiting_threads.size() >= WAITER_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				waiting_threads.push_back(tid);
				r.status = ST_BLOCKED;
			end
		end
		r.count = CNT_W'(queued_msgs.size());
		return r;
	endfunction

	function automatic logic pick_op(input int unsigned send_pct);
		return ($urandom_range(0, 99) < send_pct) ? OP_SEND : OP_RECEIVE;
	endfunction

	// Valid stays high from one beat to the next unless a gap is drawn.
	task automatic send_beat(input logic op, input logic [MSG_W-1:0] msg,
			input logic [TID_W-1:0] tid);
		int unsigned gap;
		gap = req_idle ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.operation <= op;
		req_ch.message <= msg;
		req_ch.thread_id <= tid;
		do @(posedge clk); while (!req_ch.ready);
		expected_replies.push_back(predict_mailbox(op, msg, tid));
	endtask

	task automatic send_random(input logic op);
		send_beat(op, $urandom(), TID_W'($urandom_range(0, 255)));
	endtask

	task automatic report_field(input string name, input logic [MSG_W-1:0] want,
			input logic [MSG_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	// Receiver: a random stall before each beat when rsp_idle is set, or a long hold when asked for.
	initial begin
		int unsigned stall;
		rsp_ch.ready <= 1'b0;
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			stall = rsp_idle ? $urandom_range(0, 5) : 0;
			if (rsp_hold_cycles > 0) begin
				stall = rsp_hold_cycles;
				rsp_hold_cycles = 0;
			end
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_replies.size() == 0) begin
				$display("%0t: unexpected result beat, status %0d", $time, rsp_ch.status);
				errors++;
			end else begin
				oldest_reply = expected_replies.pop_front();
				report_field("status", MSG_W'(oldest_reply.status), MSG_W'(rsp_ch.status));
				report_field("out_thread", MSG_W'(oldest_reply.thread), MSG_W'(rsp_ch.out_thread));
				report_field("out_message", oldest_reply.message, rsp_ch.out_message);
				report_field("message_count", MSG_W'(oldest_reply.count),
					MSG_W'(rsp_ch.message_count));
			end
		end
	end

	// Waiters, hand-over, queueing and delivery with the extremes of every field.
	task automatic test_directed();
		req_idle = 1'b0;
		rsp_idle = 1'b0;
		send_beat(OP_RECEIVE, 32'hFFFF_FFFF, 8'h00);
		send_beat(OP_RECEIVE, 32'h0000_0000, 8'hFF);
		send_beat(OP_SEND, 32'h0000_0000, 8'hFF);
		send_beat(OP_SEND, 32'hFFFF_FFFF, 8'h00);
		send_beat(OP_SEND, 32'h0000_0000, 8'h00);
		send_beat(OP_SEND, 32'hFFFF_FFFF, 8'hFF);
		send_beat(OP_SEND, 32'hA5A5_5A5A, 8'h3C);
		send_beat(OP_RECEIVE, 32'h1234_5678, 8'hFF);
		send_beat(OP_RECEIVE, 32'h0000_0000, 8'h00);
		send_beat(OP_RECEIVE, 32'hFFFF_FFFF, 8'h5A);
		send_beat(OP_RECEIVE, 32'h0000_0000, 8'h80);
		send_beat(OP_SEND, 32'h8000_0001, 8'h7F);
		send_beat(OP_RECEIVE, 32'h0000_0000, 8'h01);
	endtask

	// Runs of one operation push each queue past full and then drain it again.
	task automatic test_fill_bursts();
		req_idle = 1'b1;
		rsp_idle = 1'b1;
		repeat (4) begin
			repeat ($urandom_range(17, 20)) send_random(OP_SEND);
			repeat ($urandom_range(17, 20)) send_random(OP_RECEIVE);
			repeat ($urandom_range(17, 20)) send_random(OP_RECEIVE);
			repeat ($urandom_range(17, 20)) send_random(OP_SEND);
		end
	endtask

	// The receiver stops for a long stretch while requests keep coming.
	task automatic test_back_pressure();
		req_idle = 1'b0;
		rsp_idle = 1'b0;
		rsp_hold_cycles = 80;
		repeat (40) send_random(pick_op(50));
	endtask

	task automatic test_random_mix();
		int unsigned send_pct;
		for (int chunk = 0; chunk < 24; chunk++) begin
			case ($urandom_range(0, 4))
				0: send_pct = 20;
				1: send_pct = 35;
				2: send_pct = 50;
				3: send_pct = 65;
				default: send_pct = 80;
			endcase
			req_idle = (chunk % 4 != 0) && ($urandom_range(0, 3) != 0);
			rsp_idle = (chunk % 4 != 0) && ($urandom_range(0, 3) != 0);
			repeat (50) send_random(pick_op(send_pct));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.operation <= OP_SEND;
		req_ch.message <= '0;
		req_ch.thread_id <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_fill_bursts();
		test_back_pressure();
		test_random_mix();

		req_ch.valid <= 1'b0;
		while (expected_replies.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

`default_nettype wire
